[src/interval_range_map_assert.svh]
// assertion macros for the interval range map checker
// no dependencies; expects clk and rst in the scope where a macro is used
`ifndef INTERVAL_RANGE_MAP_ASSERT_SVH
`define INTERVAL_RANGE_MAP_ASSERT_SVH

// same-cycle implication
`define IRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval range map check failed");

// next-cycle implication
`define IRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval range map check failed");

`endif

[src/irm_pkg.sv]
// shared types and constants for the interval range map
// no dependencies
package irm_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 8;
  localparam int CNT_OUT_W = 7;
  localparam int POS_W = 11;
  localparam int DEPTH_DEFAULT = 64;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        val;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] pos;
    entry_t           inject;
  } cmd_t;

endpackage

[src/irm_cell.sv]
// one breakpoint cell: holds an entry, shifts with its neighbours, compares keys
// depends on irm_pkg
module irm_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  irm_pkg::cmd_t                     cmd,
  input  irm_pkg::entry_t                   left_ent,
  input  irm_pkg::entry_t                   right_ent,
  input  logic                              valid,
  input  logic signed [irm_pkg::KEY_W-1:0]  key_lo,
  input  logic signed [irm_pkg::KEY_W-1:0]  key_hi,
  output irm_pkg::entry_t                   ent,
  output logic                              lt,
  output logic                              le
);

  localparam logic [irm_pkg::POS_W-1:0] MY_POS = irm_pkg::POS_W'(IDX);

  always_ff @(posedge clk) begin
    case (cmd.op)
      irm_pkg::OP_LEFT: begin
        if (MY_POS >= cmd.pos) ent <= right_ent;
      end
      irm_pkg::OP_RIGHT: begin
        if (MY_POS > cmd.pos) ent <= left_ent;
        else if (MY_POS == cmd.pos) ent <= cmd.inject;
      end
      default: begin
        ent <= ent;
      end
    endcase
  end

  assign lt = valid && ($signed(ent.key) < key_lo);
  assign le = valid && ($signed(ent.key) <= key_hi);

endmodule

[src/interval_range_map.sv]
// interval range map top level: control sequencer, selection trees, cell chain
// depends on irm_pkg and irm_cell
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | action key_begin key_end new_value query_key
//  output   | out_valid / out_stall| found_value overflow entry_count
//  config   | cfg_valid / cfg_ready| cfg_data (initial value)
//
// lookup, empty range or refused assign: CMP, SEL and PLAN, then DONE loads the result
// assign: CMP, SEL, PLAN, DEL shifting out each deleted entry, then DROP, INSE, INSB, DONE
// one transaction at a time; input stalls until the result is in the output register
// a held result does not block the next input; rst is synchronous, clears count and control
module interval_range_map #(
  parameter int DEPTH = irm_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic signed [irm_pkg::KEY_W-1:0]  key_begin,
  input  logic signed [irm_pkg::KEY_W-1:0]  key_end,
  input  logic [irm_pkg::VAL_W-1:0]         new_value,
  input  logic signed [irm_pkg::KEY_W-1:0]  query_key,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [irm_pkg::VAL_W-1:0]         found_value,
  output logic                              overflow,
  output logic [irm_pkg::CNT_OUT_W-1:0]     entry_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irm_pkg::VAL_W-1:0]         cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = CW + 2;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CMP  = 9'b000000010,
    S_SEL  = 9'b000000100,
    S_PLAN = 9'b000001000,
    S_DEL  = 9'b000010000,
    S_INSE = 9'b000100000,
    S_INSB = 9'b001000000,
    S_DROP = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [irm_pkg::VAL_W-1:0] init;
  logic [CW-1:0]             count;

  logic                             act;
  logic                             range_ok;
  logic signed [irm_pkg::KEY_W-1:0] kb, ke, khi;
  logic [irm_pkg::VAL_W-1:0]        v;

  logic [DEPTH-1:0] lt_r, le_r, valid;
  logic [DEPTH-1:0] lt_c, le_c;

  irm_pkg::entry_t ent [DEPTH];
  irm_pkg::cmd_t   cmd;

  logic [CW-1:0]             p, q, p_c, q_c;
  logic [irm_pkg::VAL_W-1:0] pv, hv, sv, val0, pv_c, hv_c, sv_c;
  logic                      has_p, has_q;

  logic [irm_pkg::VAL_W-1:0] lastb, endv;
  logic                      drop0_c, keepb_c, keepe_c, sfx_c, drops_c, ovf_c;
  logic [NW-1:0]             n_c;
  logic [CW-1:0]             del_c;

  logic [CW-1:0]             del_cnt;
  logic                      keep_b, keep_e, drop0;
  logic [CW-1:0]             n_r;
  logic [irm_pkg::VAL_W-1:0] endv_r, res_found;
  logic                      res_ovf;
  logic                      out_load;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid[i] = count > CW'(i);
    irm_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_ent  (ent[(i == 0) ? 0 : i - 1]),
      .right_ent (ent[(i == DEPTH - 1) ? i : i + 1]),
      .valid     (valid[i]),
      .key_lo    (kb),
      .key_hi    (khi),
      .ent       (ent[i]),
      .lt        (lt_c[i]),
      .le        (le_c[i])
    );
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  // boundary selection over the registered compare masks
  always_comb begin
    logic [DEPTH:0] lt_x, le_x, le_p;
    lt_x = {1'b0, lt_r};
    le_x = {1'b0, le_r};
    le_p = {le_r, 1'b1};
    p_c  = '0;
    q_c  = '0;
    pv_c = '0;
    hv_c = '0;
    sv_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lt_x[i] && !lt_x[i+1]) begin
        p_c  = p_c | CW'(i + 1);
        pv_c = pv_c | ent[i].val;
      end
      if (le_x[i] && !le_x[i+1]) begin
        q_c  = q_c | CW'(i + 1);
        hv_c = hv_c | ent[i].val;
      end
      // first entry above the range end
      if (!le_x[i] && le_p[i] && valid[i]) sv_c = sv_c | ent[i].val;
    end
  end

  // rebuild plan
  always_comb begin
    lastb   = has_p ? pv : init;
    endv    = has_q ? hv : init;
    drop0_c = has_p && (val0 == init);
    keepb_c = (v != lastb);
    keepe_c = (endv != v);
    sfx_c   = (q < count);
    drops_c = sfx_c && (sv == endv);
    n_c = NW'(p) - NW'(drop0_c) + NW'(keepb_c) + NW'(keepe_c)
        + NW'(count) - NW'(q) - NW'(drops_c);
    ovf_c = (n_c > NW'(DEPTH));
    del_c = q - p + CW'(drops_c);
  end

  // the head entry goes before the inserts, so the chain never holds more than DEPTH
  always_comb begin
    cmd = '{op: irm_pkg::OP_HOLD, pos: '0, inject: '0};
    case (state)
      S_DEL: begin
        if (del_cnt != '0) begin
          cmd.op  = irm_pkg::OP_LEFT;
          cmd.pos = irm_pkg::POS_W'(p);
        end
      end
      S_INSE: begin
        if (keep_e) begin
          cmd.op     = irm_pkg::OP_RIGHT;
          cmd.pos    = irm_pkg::POS_W'(p - CW'(drop0));
          cmd.inject = '{key: ke, val: endv_r};
        end
      end
      S_INSB: begin
        if (keep_b) begin
          cmd.op     = irm_pkg::OP_RIGHT;
          cmd.pos    = irm_pkg::POS_W'(p - CW'(drop0));
          cmd.inject = '{key: kb, val: v};
        end
      end
      S_DROP: begin
        if (drop0) begin
          cmd.op  = irm_pkg::OP_LEFT;
          cmd.pos = '0;
        end
      end
      default: begin
        cmd.op = irm_pkg::OP_HOLD;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_CMP;
      S_CMP:  state_next = S_SEL;
      S_SEL:  state_next = S_PLAN;
      S_PLAN: begin
        if (act || !range_ok || ovf_c) state_next = S_DONE;
        else state_next = S_DEL;
      end
      S_DEL:  if (del_cnt == '0) state_next = S_DROP;
      S_DROP: state_next = S_INSE;
      S_INSE: state_next = S_INSB;
      S_INSB: state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      init      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) init <= cfg_data;
      if (state == S_INSB) count <= n_r;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      act      <= action;
      kb       <= key_begin;
      ke       <= key_end;
      v        <= new_value;
      khi      <= action ? query_key : key_end;
      range_ok <= (key_begin < key_end);
    end
    if (state == S_CMP) begin
      lt_r <= lt_c;
      le_r <= le_c;
    end
    if (state == S_SEL) begin
      p     <= p_c;
      q     <= q_c;
      pv    <= pv_c;
      hv    <= hv_c;
      sv    <= sv_c;
      has_p <= lt_r[0];
      has_q <= le_r[0];
      val0  <= ent[0].val;
    end
    if (state == S_PLAN) begin
      del_cnt   <= del_c;
      keep_b    <= keepb_c;
      keep_e    <= keepe_c;
      drop0     <= drop0_c;
      n_r       <= CW'(n_c);
      endv_r    <= endv;
      res_found <= act ? endv : '0;
      res_ovf   <= !act && range_ok && ovf_c;
    end
    if (state == S_DEL && del_cnt != '0) del_cnt <= del_cnt - CW'(1);
    if (out_load) begin
      found_value <= res_found;
      overflow    <= res_ovf;
      entry_count <= irm_pkg::CNT_OUT_W'(count);
    end
  end

endmodule

[src/irm_checker.sv]
// port-level checks for the interval range map, bound to the top level
// depends on irm_pkg and interval_range_map_assert.svh
`include "interval_range_map_assert.svh"

module irm_checker #(
  parameter int DEPTH = irm_pkg::DEPTH_DEFAULT
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [irm_pkg::VAL_W-1:0]         found_value,
  input logic                              overflow,
  input logic [irm_pkg::CNT_OUT_W-1:0]     entry_count
);

  // the input stalls once a transaction has been accepted
  `IRM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a held result stays offered
  `IRM_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid)

  // a refused assign never reports a lookup value
  `IRM_ASSERT_IMP(a_ovf_no_value, out_valid && overflow, found_value == '0)

  // table never holds more than its depth
  `IRM_ASSERT_IMP(a_count_bound, out_valid, (DEPTH > 127) || (int'(entry_count) <= DEPTH))

endmodule

bind interval_range_map irm_checker #(.DEPTH(DEPTH)) u_irm_checker (.*);

[bench/tb_interval_range_map.sv]
// self-checking bench for the interval range map: random and directed assigns and lookups
// depends on irm_pkg and the interval_range_map top level; holds its own table predictor
module tb_interval_range_map;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = irm_pkg::DEPTH_DEFAULT;
  localparam logic ACT_ASSIGN = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct {
    logic [7:0] found;
    logic       ovf;
    logic [6:0] count;
  } map_result_t;

  class map_scoreboard;
    int signed   keys[$];
    logic [7:0]  vals[$];
    logic [7:0]  base_value;
    map_result_t pending[$];
    int          errors;

    function logic [7:0] value_at(int signed k);
      logic [7:0] v;
      v = base_value;
      foreach (keys[i]) begin
        if (keys[i] <= k) v = vals[i];
        else break;
      end
      return v;
    endfunction

    // rebuild the table in canonical form; leave it for an empty range, refuse if it would not fit
    function logic apply_range(int signed b, int signed e, logic [7:0] v);
      int signed  nk[$];
      logic [7:0] nv[$];
      logic [7:0] tail, last;
      if (!(b < e)) return 1'b0;
      tail = value_at(e);
      last = base_value;
      foreach (keys[i])
        if (keys[i] < b && vals[i] != last) begin
          nk.push_back(keys[i]); nv.push_back(vals[i]); last = vals[i];
        end
      if (v != last) begin nk.push_back(b); nv.push_back(v); last = v; end
      if (tail != last) begin nk.push_back(e); nv.push_back(tail); last = tail; end
      foreach (keys[i])
        if (keys[i] > e && vals[i] != last) begin
          nk.push_back(keys[i]); nv.push_back(vals[i]); last = vals[i];
        end
      if (nk.size() > DEPTH) return 1'b1;
      keys = nk;
      vals = nv;
      return 1'b0;
    endfunction

    function void note_input(logic act, int signed kb, int signed ke, logic [7:0] nv,
                             int signed kq);
      map_result_t r;
      r.found = '0;
      r.ovf = 1'b0;
      if (act == ACT_LOOKUP) r.found = value_at(kq);
      else r.ovf = apply_range(kb, ke, nv);
      r.count = 7'(keys.size());
      pending.push_back(r);
    endfunction

    function void check_result(logic [7:0] f, logic o, logic [6:0] c);
      map_result_t r;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      r = pending.pop_front();
      if (f !== r.found) begin
        $error("found_value expected %0d got %0d", r.found, f); errors++;
      end
      if (o !== r.ovf) begin
        $error("overflow expected %0d got %0d", r.ovf, o); errors++;
      end
      if (c !== r.count) begin
        $error("entry_count expected %0d got %0d", r.count, c); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, action = 0;
  logic signed [31:0] key_begin = 0, key_end = 0, query_key = 0;
  logic [7:0] new_value = 0, found_value, cfg_data = 0;
  logic out_valid, out_stall = 0, overflow, cfg_valid = 0, cfg_ready;
  logic [6:0] entry_count;

  map_scoreboard sb = new();
  bit quiet_tail = 0, hold_off = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  interval_range_map DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(found_value, overflow, entry_count);

  // receiver stall: random bursts, one long hold-off on request, none at the tail
  initial begin
    int n;
    bit held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        out_stall <= 1;
        repeat (300) @(negedge clk);
        out_stall <= 0;
        held = 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n - 1) @(negedge clk);
      end else out_stall <= 0;
    end
  end

  task automatic send(logic act, int signed kb, int signed ke, logic [7:0] nv,
                      int signed kq);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    action <= act; key_begin <= kb; key_end <= ke; new_value <= nv; query_key <= kq;
    do @(posedge clk); while (in_stall);
    sb.note_input(act, kb, ke, nv, kq);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_base(logic [7:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.base_value = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic int signed near_key(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic random_item(int span, int nvals);
    int signed a, b;
    logic [7:0] v;
    a = near_key(span);
    b = a + $urandom_range(1, span / 2 + 1);
    v = 8'($urandom_range(0, nvals - 1));
    case ($urandom_range(0, 9))
      0: send(ACT_ASSIGN, $urandom, $urandom, 8'($urandom), $urandom);
      1: send(ACT_LOOKUP, $urandom, $urandom, 8'($urandom), $urandom);
      2, 3, 4: send(ACT_LOOKUP, $urandom, $urandom, 8'($urandom), near_key(span));
      5: send(ACT_ASSIGN, b, a, v, $urandom);
      default: send(ACT_ASSIGN, a, b, v, $urandom);
    endcase
  endtask

  initial begin
    int signed kmin, kmax;
    kmin = 32'sh8000_0000;
    kmax = 32'sh7fff_ffff;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    write_base(8'd0);

    // extremes, empty ranges, lookups across the whole key space
    send(ACT_LOOKUP, 0, 0, 0, kmin);
    send(ACT_ASSIGN, kmin, kmax, 8'hff, 0);
    send(ACT_LOOKUP, 0, 0, 0, kmin);
    send(ACT_LOOKUP, 0, 0, 0, kmax);
    send(ACT_ASSIGN, 5, 5, 8'h11, 0);
    send(ACT_ASSIGN, 9, -3, 8'h11, 0);
    send(ACT_ASSIGN, -10, 10, 8'h00, 0);
    send(ACT_LOOKUP, 0, 0, 0, 0);
    send(ACT_LOOKUP, 0, 0, 0, 10);
    send(ACT_ASSIGN, kmin, kmax, 8'h00, 0);
    send(ACT_ASSIGN, 0, 1, 8'h00, 0);
    send(ACT_ASSIGN, -1, kmax, 8'haa, kmax);
    send(ACT_LOOKUP, 0, 0, 0, -1);
    drain();
    // base value now equals an entry, which the next rebuild removes
    write_base(8'haa);
    send(ACT_ASSIGN, 100, 200, 8'h55, 0);
    send(ACT_LOOKUP, 0, 0, 0, 0);
    send(ACT_LOOKUP, 0, 0, 0, 150);
    // fill to overflow with alternating values
    for (int i = 0; i < 40; i++) send(ACT_ASSIGN, 1000 + 4 * i, 1002 + 4 * i, 8'(i[0]), 0);
    drain();

    // phases with different base values, pressure on the second one
    for (int ph = 0; ph < 6; ph++) begin
      write_base(ph == 0 ? 8'h00 : ph == 1 ? 8'hff : 8'($urandom));
      if (ph == 1) hold_off = 1;
      if (ph == 5) quiet_tail = 1;
      for (int i = 0; i < 300; i++)
        random_item(ph[0] ? 60 : 2000, ph == 2 ? 256 : 4);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/irm_pkg.sv
src/irm_cell.sv
src/interval_range_map.sv
src/irm_checker.sv
bench/tb_interval_range_map.sv
